>>> src/oggd_pkg.sv
// shared types, constants and capture patterns for the ogg opus page demux
package oggd_pkg;

  // default number of lacing entries kept per page
  localparam int unsigned LacingDepthDef = 255;

  // page header layout
  localparam logic [4:0] HdrMagicLen   = 5'd4;
  localparam logic [4:0] HdrVersionIdx = 5'd4;
  localparam logic [4:0] HdrLastIdx    = 5'd26;

  // lacing values
  localparam logic [7:0] LacingLastIdx = 8'd254;
  localparam logic [7:0] SegFull       = 8'd255;

  // packet identification
  localparam logic [3:0] MatchLen   = 4'd8;
  localparam logic [3:0] ChanPos    = 4'd9;
  localparam logic [3:0] TagsMinLen = 4'd8;
  localparam logic [3:0] HeadMinLen = 4'd10;
  localparam logic [3:0] LenSatMax  = 4'd15;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_LACING,
    PH_PAYLOAD,
    PH_HALTED
  } phase_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    KIND_IGNORED,
    KIND_HEAD,
    KIND_TAGS,
    KIND_AUDIO
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE,
    ERR_MAGIC,
    ERR_CHANNELS
  } err_e;

  // commands from the page parser to the packet tracker
  typedef struct packed {
    logic restart;
    logic abandon;
    logic take;
    logic close;
  } pkt_ctl_t;

  // packet tracker status
  typedef struct packed {
    logic       open;
    logic       bad_chan;
    kind_e      kind;
    logic [1:0] acc_chan;
    logic [1:0] head_chan;
  } pkt_stat_t;

  // "OggS"
  function automatic logic [7:0] page_magic(input logic [1:0] idx);
    logic [7:0] c;
    unique case (idx)
      2'd0: c = 8'h4F;
      2'd1: c = 8'h67;
      2'd2: c = 8'h67;
      2'd3: c = 8'h53;
    endcase
    return c;
  endfunction

  // "OpusHead"
  function automatic logic [7:0] head_magic(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0: c = 8'h4F;
      3'd1: c = 8'h70;
      3'd2: c = 8'h75;
      3'd3: c = 8'h73;
      3'd4: c = 8'h48;
      3'd5: c = 8'h65;
      3'd6: c = 8'h61;
      3'd7: c = 8'h64;
    endcase
    return c;
  endfunction

  // "OpusTags"
  function automatic logic [7:0] tags_magic(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0: c = 8'h4F;
      3'd1: c = 8'h70;
      3'd2: c = 8'h75;
      3'd3: c = 8'h73;
      3'd4: c = 8'h54;
      3'd5: c = 8'h61;
      3'd6: c = 8'h67;
      3'd7: c = 8'h73;
    endcase
    return c;
  endfunction

endpackage

>>> src/ogg_opus_page_demux_core.sv
// ogg opus page demux top level: page parser, packet tracker, lacing ram and output register
//
// Takes an Ogg Opus file one byte per input transaction and returns the packet payload bytes,
// each packet's last result carrying its kind (ignored, head, tags, audio). A header byte, a
// lacing byte other than the last of its page and a payload byte inside a segment go from
// idle to execute and back, a payload byte by way of the emit state when the output is occupied
// and a bad page's last header byte always. The last lacing byte of a page and the byte that
// completes a segment then step through the lacing table to the next non-zero segment, reading
// and checking one entry at a time, or to the end of the page's entries, since the lacing table
// sits in a single-read-port RAM with registered read data. The lacing table holds no reset
// value; every entry is written on its page before it is read. A finished result waits in the
// output register while the next byte is accepted; the parser stalls only when it has a new
// result and that register is still occupied. A bad page header or a bad channel count in the
// head packet stops all further output after its error result until a byte with file_start set.
module ogg_opus_page_demux_core import oggd_pkg::*; #(
  parameter int unsigned LACING_DEPTH = LacingDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       file_start_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] payload_byte_o,
  output logic       byte_valid_o,
  output logic       packet_end_o,
  output logic [1:0] packet_kind_o,
  output logic [1:0] channel_count_o,
  output logic [1:0] error_code_o
);

  localparam int unsigned AddrW  = (LACING_DEPTH > 1) ? $clog2(LACING_DEPTH) : 1;
  localparam logic [7:0]  DepthB = 8'(LACING_DEPTH);

  state_e     state_q, state_d;
  phase_e     phase_q;
  logic [4:0] hdr_idx_q;
  logic       magic_ok_q;
  logic [7:0] seg_count_q;
  logic [7:0] tbl_idx_q;
  logic [7:0] seg_left_q;
  logic [7:0] cur_len_q;
  err_e       sticky_q;
  logic       mark_q;
  logic       bval_q;
  logic       ends_q;
  logic [7:0] byte_q;

  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       out_bval_q;
  logic       out_end_q;
  kind_e      out_kind_q;
  logic [1:0] out_chan_q;
  err_e       out_err_q;

  logic       accept;
  logic       out_free;
  logic       exec_live;
  logic [7:0] used;
  logic [7:0] tbl_inc;
  logic       lace_more;
  logic [7:0] seg_left_dec;
  logic       direct;
  logic       do_emit;
  logic       load_out;
  logic       ld_bval;
  logic       ld_end;
  logic       ram_we;
  logic       ram_re;
  logic [7:0] ram_rdata;
  pkt_ctl_t   pkt_ctl;
  pkt_stat_t  pkt_stat;

  // helpers shared by the control and datapath
  assign accept       = in_valid_i && in_ready_o;
  assign out_free     = !out_valid_q || out_ready_i;
  assign exec_live    = (state_q == ST_EXEC) && (sticky_q == ERR_NONE);
  assign used         = (seg_count_q < DepthB) ? seg_count_q : DepthB;
  assign tbl_inc      = tbl_idx_q + 8'd1;
  assign lace_more    = (tbl_inc < seg_count_q) && (tbl_idx_q < LacingLastIdx);
  assign seg_left_dec = (seg_left_q != 8'd0) ? seg_left_q - 8'd1 : 8'd0;
  assign do_emit      = bval_q || ends_q || mark_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sticky_q != ERR_NONE) begin
          state_d = ST_IDLE;
        end else begin
          unique case (phase_q)
            PH_HEADER: begin
              state_d = (hdr_idx_q == HdrLastIdx && !magic_ok_q) ? ST_EMIT : ST_IDLE;
            end
            PH_LACING: begin
              state_d = lace_more ? ST_IDLE : ST_SCAN_RD;
            end
            PH_PAYLOAD: begin
              if (seg_left_dec == 8'd0) begin
                state_d = ST_SCAN_RD;
              end else begin
                state_d = out_free ? ST_IDLE : ST_EMIT;
              end
            end
            PH_HALTED: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_SCAN_RD: begin
        state_d = (tbl_idx_q >= used) ? ST_EMIT : ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        state_d = (ram_rdata == 8'd0) ? ST_SCAN_RD : ST_EMIT;
      end
      ST_EMIT: begin
        if (!do_emit || out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control outputs
  always_comb begin
    in_ready_o      = (state_q == ST_IDLE);
    ram_we          = exec_live && (phase_q == PH_LACING) && (tbl_idx_q < DepthB);
    ram_re          = (state_q == ST_SCAN_RD) && (tbl_idx_q < used);
    direct          = exec_live && (phase_q == PH_PAYLOAD) && (seg_left_dec != 8'd0);
    load_out        = out_free && (direct || (state_q == ST_EMIT && do_emit));
    ld_bval         = direct ? 1'b1 : bval_q;
    ld_end          = direct ? 1'b0 : ends_q;
    pkt_ctl.restart = accept && file_start_i;
    pkt_ctl.abandon = exec_live && (phase_q == PH_HEADER) && (hdr_idx_q == HdrLastIdx)
                      && !magic_ok_q;
    pkt_ctl.take    = exec_live && (phase_q == PH_PAYLOAD);
    pkt_ctl.close   = load_out && ld_end;
  end

  // lacing table
  oggd_ram #(
    .WIDTH(8),
    .DEPTH(LACING_DEPTH)
  ) u_lacing_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(tbl_idx_q[AddrW-1:0]),
    .wdata_i(byte_q),
    .re_i   (ram_re),
    .raddr_i(tbl_idx_q[AddrW-1:0]),
    .rdata_o(ram_rdata)
  );

  // packet tracking
  oggd_pkt u_pkt (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (pkt_ctl),
    .byte_i(byte_q),
    .stat_o(pkt_stat)
  );

  // input byte holding register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= data_byte_i;
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_HEADER;
      hdr_idx_q   <= '0;
      magic_ok_q  <= 1'b1;
      seg_count_q <= '0;
      tbl_idx_q   <= '0;
      seg_left_q  <= '0;
      cur_len_q   <= '0;
      sticky_q    <= ERR_NONE;
      mark_q      <= 1'b0;
      bval_q      <= 1'b0;
      ends_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        ST_IDLE: begin
          // new file: back to the reset view
          if (accept && file_start_i) begin
            phase_q     <= PH_HEADER;
            hdr_idx_q   <= '0;
            magic_ok_q  <= 1'b1;
            seg_count_q <= '0;
            tbl_idx_q   <= '0;
            seg_left_q  <= '0;
            sticky_q    <= ERR_NONE;
          end
        end
        ST_EXEC: begin
          if (sticky_q == ERR_NONE) begin
            mark_q <= 1'b0;
            bval_q <= 1'b0;
            ends_q <= 1'b0;
            unique case (phase_q)
              PH_HEADER: begin
                // capture pattern and version check
                if (hdr_idx_q < HdrMagicLen) begin
                  if (byte_q != page_magic(hdr_idx_q[1:0])) begin
                    magic_ok_q <= 1'b0;
                  end
                end else if (hdr_idx_q == HdrVersionIdx) begin
                  if (byte_q != 8'd0) begin
                    magic_ok_q <= 1'b0;
                  end
                end
                if (hdr_idx_q < HdrLastIdx) begin
                  hdr_idx_q <= hdr_idx_q + 5'd1;
                end else begin
                  hdr_idx_q <= '0;
                  if (!magic_ok_q) begin
                    sticky_q <= ERR_MAGIC;
                    phase_q  <= PH_HALTED;
                    mark_q   <= 1'b1;
                  end else begin
                    seg_count_q <= byte_q;
                    tbl_idx_q   <= '0;
                    if (byte_q != 8'd0) begin
                      phase_q <= PH_LACING;
                    end
                  end
                end
              end
              PH_LACING: begin
                if (lace_more) begin
                  tbl_idx_q <= tbl_inc;
                end else begin
                  phase_q   <= PH_PAYLOAD;
                  tbl_idx_q <= '0;
                end
              end
              PH_PAYLOAD: begin
                bval_q     <= 1'b1;
                seg_left_q <= seg_left_dec;
                if (seg_left_dec == 8'd0) begin
                  ends_q    <= (cur_len_q != SegFull);
                  tbl_idx_q <= tbl_inc;
                end
              end
              PH_HALTED: begin
              end
            endcase
          end
        end
        ST_SCAN_RD: begin
          // lacing table used up: next byte starts a page header
          if (tbl_idx_q >= used) begin
            phase_q    <= PH_HEADER;
            hdr_idx_q  <= '0;
            seg_left_q <= '0;
          end
        end
        ST_SCAN_CHK: begin
          // zero entries end an open packet and are skipped
          if (ram_rdata == 8'd0) begin
            if (pkt_stat.open) begin
              ends_q <= 1'b1;
            end
            tbl_idx_q <= tbl_inc;
          end else begin
            seg_left_q <= ram_rdata;
            cur_len_q  <= ram_rdata;
          end
        end
        ST_EMIT: begin
          if (load_out && ld_end && pkt_stat.bad_chan) begin
            sticky_q <= ERR_CHANNELS;
            phase_q  <= PH_HALTED;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_byte_q <= ld_bval ? byte_q : 8'd0;
      out_bval_q <= ld_bval;
      out_end_q  <= ld_end;
      out_kind_q <= ld_end ? pkt_stat.kind : KIND_IGNORED;
      out_chan_q <= (ld_end && pkt_stat.kind == KIND_HEAD) ? pkt_stat.head_chan
                                                            : pkt_stat.acc_chan;
      out_err_q  <= (ld_end && pkt_stat.bad_chan) ? ERR_CHANNELS : sticky_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign payload_byte_o  = out_byte_q;
  assign byte_valid_o    = out_bval_q;
  assign packet_end_o    = out_end_q;
  assign packet_kind_o   = out_kind_q;
  assign channel_count_o = out_chan_q;
  assign error_code_o    = out_err_q;

  // a sticky error always comes with the halted phase
  a_err_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sticky_q != ERR_NONE) |-> (phase_q == PH_HALTED))
    else $error("sticky error without halted phase");

  // the table is only examined while the page payload is being walked
  a_scan_in_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN_CHK) |-> (phase_q == PH_PAYLOAD))
    else $error("lacing scan outside payload phase");

  // the table is only written while lacing bytes arrive
  a_write_in_lacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (phase_q == PH_LACING && state_q == ST_EXEC))
    else $error("lacing ram written outside lacing phase");

  // between scans the table index points at a live segment
  a_idx_in_page: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PAYLOAD && state_q != ST_SCAN_RD && state_q != ST_SCAN_CHK
     && !(state_q == ST_EMIT && ends_q == 1'b0 && bval_q == 1'b0))
    |-> (tbl_idx_q < used || state_q == ST_EMIT))
    else $error("table index past the used lacing entries");

endmodule

>>> src/oggd_ram.sv
// generic single-write, single-read ram with registered read data
module oggd_ram #(
  parameter  int unsigned WIDTH = 8,
  parameter  int unsigned DEPTH = 2,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/oggd_pkt.sv
// packet tracker: identifies head and tags packets and keeps stream flags
module oggd_pkt import oggd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  pkt_ctl_t   ctl_i,
  input  logic [7:0] byte_i,
  output pkt_stat_t  stat_o
);

  logic       open_q;
  logic [3:0] len_q;
  logic       head_m_q;
  logic       tags_m_q;
  logic [7:0] head_ch_q;
  logic       seen_head_q;
  logic       seen_tags_q;
  logic [1:0] acc_ch_q;

  logic  head_cand;
  logic  ch_ok;
  kind_e kind;
  logic  bad_chan;

  // classification of the packet that would close now
  always_comb begin
    head_cand = !seen_head_q && (len_q >= HeadMinLen) && head_m_q;
    ch_ok     = (head_ch_q == 8'd1) || (head_ch_q == 8'd2);
    bad_chan  = 1'b0;
    kind      = KIND_IGNORED;
    if (head_cand) begin
      if (ch_ok) begin
        kind = KIND_HEAD;
      end else begin
        bad_chan = 1'b1;
      end
    end else if (seen_head_q && !seen_tags_q && (len_q >= TagsMinLen) && tags_m_q) begin
      kind = KIND_TAGS;
    end else if (seen_head_q && seen_tags_q) begin
      kind = KIND_AUDIO;
    end
  end

  assign stat_o.open      = open_q;
  assign stat_o.bad_chan  = bad_chan;
  assign stat_o.kind      = kind;
  assign stat_o.acc_chan  = acc_ch_q;
  assign stat_o.head_chan = head_ch_q[1:0];

  // packet and stream state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q      <= 1'b0;
      len_q       <= '0;
      head_m_q    <= 1'b1;
      tags_m_q    <= 1'b1;
      head_ch_q   <= '0;
      seen_head_q <= 1'b0;
      seen_tags_q <= 1'b0;
      acc_ch_q    <= '0;
    end else if (ctl_i.restart) begin
      open_q      <= 1'b0;
      len_q       <= '0;
      head_m_q    <= 1'b1;
      tags_m_q    <= 1'b1;
      head_ch_q   <= '0;
      seen_head_q <= 1'b0;
      seen_tags_q <= 1'b0;
      acc_ch_q    <= '0;
    end else if (ctl_i.abandon || ctl_i.close) begin
      if (ctl_i.close && kind == KIND_HEAD) begin
        seen_head_q <= 1'b1;
        acc_ch_q    <= head_ch_q[1:0];
      end
      if (ctl_i.close && kind == KIND_TAGS) begin
        seen_tags_q <= 1'b1;
      end
      open_q    <= 1'b0;
      len_q     <= '0;
      head_m_q  <= 1'b1;
      tags_m_q  <= 1'b1;
      head_ch_q <= '0;
    end else if (ctl_i.take) begin
      if (len_q < MatchLen) begin
        if (byte_i != head_magic(len_q[2:0])) begin
          head_m_q <= 1'b0;
        end
        if (byte_i != tags_magic(len_q[2:0])) begin
          tags_m_q <= 1'b0;
        end
      end else if (len_q == ChanPos) begin
        head_ch_q <= byte_i;
      end
      if (len_q < LenSatMax) begin
        len_q <= len_q + 4'd1;
      end
      open_q <= 1'b1;
    end
  end

  // a closing head packet marks the head as seen
  a_head_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.close && !ctl_i.restart && kind == KIND_HEAD) |=> seen_head_q)
    else $error("head packet closed without marking head seen");

  // tags are only taken after the head
  a_tags_after_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_tags_q |-> seen_head_q)
    else $error("tags seen before head");

  // an accepted channel count exists exactly when the head was seen
  a_chan_with_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_ch_q != 2'd0) == seen_head_q)
    else $error("channel count out of step with head flag");

endmodule

>>> tb/tb_ogg_opus_page_demux_core.sv
// testbench for the ogg opus page demux core: generated ogg files in, predicted packet bytes out
`timescale 1ns / 100ps

module tb_ogg_opus_page_demux_core;
  import oggd_pkg::*;

  localparam int unsigned LACE_N      = LacingDepthDef;
  localparam int          RAND_BYTES  = 500;
  localparam int          PAUSE_AT    = 120;   // sender waits for the output to drain here
  localparam int          HOLD_AT     = 200;   // receiver goes quiet after this many results
  localparam int          HOLD_CYCLES = 300;
  localparam int          DRAIN_CYCLES = 600;
  localparam int          TIMEOUT_NS  = 2_000_000;

  localparam logic [31:0] CAP_PAT  = "OggS";
  localparam logic [63:0] HEAD_PAT = "OpusHead";
  localparam logic [63:0] TAGS_PAT = "OpusTags";

  typedef enum int {
    PKT_RAW,
    PKT_HEAD,
    PKT_TAGS
  } pkt_e;

  typedef struct packed {
    logic [7:0] data;
    logic       fs;
  } ogg_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       dvalid;
    logic       pend;
    kind_e      kind;
    logic [1:0] chans;
    err_e       err;
  } demux_res_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] data_byte_i = 8'd0;
  logic       file_start_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] payload_byte_o;
  logic       byte_valid_o;
  logic       packet_end_o;
  logic [1:0] packet_kind_o;
  logic [1:0] channel_count_o;
  logic [1:0] error_code_o;

  ogg_item_t  ogg_bytes_q[$];
  demux_res_t demux_out_q[$];
  logic [7:0] file_q[$];
  logic [7:0] lace_q[$];
  logic [7:0] body_q[$];
  int         n_errors = 0;
  int         n_taken = 0;
  int         n_results = 0;

  ogg_opus_page_demux_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .file_start_i   (file_start_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .payload_byte_o (payload_byte_o),
    .byte_valid_o   (byte_valid_o),
    .packet_end_o   (packet_end_o),
    .packet_kind_o  (packet_kind_o),
    .channel_count_o(channel_count_o),
    .error_code_o   (error_code_o)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // demux predictor state
  phase_e     dm_phase;
  logic [4:0] dm_hdr_idx;
  logic       dm_page_ok;
  logic [7:0] dm_seg_cnt;
  logic [7:0] dm_lace [LACE_N];
  logic [7:0] dm_tbl_idx;
  logic [7:0] dm_seg_left;
  logic       dm_pkt_open;
  logic [3:0] dm_pkt_len;
  logic       dm_is_head;
  logic       dm_is_tags;
  logic [7:0] dm_head_ch;
  logic       dm_got_head;
  logic       dm_got_tags;
  logic [1:0] dm_chans;
  err_e       dm_err;

  function automatic void drop_packet();
    dm_pkt_open = 1'b0;
    dm_pkt_len  = 4'd0;
    dm_is_head  = 1'b1;
    dm_is_tags  = 1'b1;
    dm_head_ch  = 8'd0;
  endfunction

  function automatic void clear_demux();
    dm_phase    = PH_HEADER;
    dm_hdr_idx  = 5'd0;
    dm_page_ok  = 1'b1;
    dm_seg_cnt  = 8'd0;
    dm_tbl_idx  = 8'd0;
    dm_seg_left = 8'd0;
    drop_packet();
    dm_got_head = 1'b0;
    dm_got_tags = 1'b0;
    dm_chans    = 2'd0;
    dm_err      = ERR_NONE;
  endfunction

  function automatic logic [7:0] entry_at(input logic [7:0] i);
    return (i < LACE_N) ? dm_lace[i] : 8'd0;
  endfunction

  // classify the packet that ends now
  function automatic kind_e close_packet_now();
    kind_e k;
    k = KIND_IGNORED;
    if (!dm_got_head && dm_pkt_len >= HeadMinLen && dm_is_head) begin
      if (dm_head_ch == 8'd1 || dm_head_ch == 8'd2) begin
        dm_chans    = dm_head_ch[1:0];
        dm_got_head = 1'b1;
        k = KIND_HEAD;
      end else begin
        dm_err = ERR_CHANNELS;
      end
    end else if (dm_got_head && !dm_got_tags && dm_pkt_len >= TagsMinLen && dm_is_tags) begin
      dm_got_tags = 1'b1;
      k = KIND_TAGS;
    end else if (dm_got_head && dm_got_tags) begin
      k = KIND_AUDIO;
    end
    drop_packet();
    return k;
  endfunction

  // step over zero lacing entries; an open packet ends on any of them
  function automatic logic skip_zero_entries(input logic ends);
    logic [7:0] used;
    used = (dm_seg_cnt < LACE_N) ? dm_seg_cnt : 8'(LACE_N);
    while (dm_tbl_idx < used && entry_at(dm_tbl_idx) == 8'd0) begin
      if (dm_pkt_open) ends = 1'b1;
      dm_tbl_idx++;
    end
    if (dm_tbl_idx >= used) begin
      dm_phase    = PH_HEADER;
      dm_hdr_idx  = 5'd0;
      dm_seg_left = 8'd0;
    end else begin
      dm_seg_left = entry_at(dm_tbl_idx);
    end
    return ends;
  endfunction

  function automatic demux_res_t make_res(input logic [7:0] b, input logic v, input logic e,
                                          input kind_e k);
    demux_res_t r;
    r.data   = v ? b : 8'd0;
    r.dvalid = v;
    r.pend   = e;
    r.kind   = KIND_IGNORED;
    if (e) r.kind = k;
    r.chans  = dm_chans;
    r.err    = dm_err;
    return r;
  endfunction

  // one file byte through the demux, at most one result
  task automatic demux_byte(input logic [7:0] b, input logic fs, output logic has_res,
                            output demux_res_t r);
    logic       ends;
    kind_e      k;
    logic [3:0] pos;
    logic [7:0] seg_len;
    has_res = 1'b0;
    r = '0;
    k = KIND_IGNORED;
    if (fs) clear_demux();
    if (dm_err != ERR_NONE) return;
    case (dm_phase)
      PH_HEADER: begin
        if (dm_hdr_idx < HdrMagicLen) begin
          if (b != CAP_PAT[31 - 8 * dm_hdr_idx -: 8]) dm_page_ok = 1'b0;
        end else if (dm_hdr_idx == HdrVersionIdx) begin
          if (b != 8'd0) dm_page_ok = 1'b0;
        end
        if (dm_hdr_idx < HdrLastIdx) begin
          dm_hdr_idx++;
          return;
        end
        dm_hdr_idx = 5'd0;
        if (!dm_page_ok) begin
          dm_err   = ERR_MAGIC;
          dm_phase = PH_HALTED;
          drop_packet();
          has_res = 1'b1;
          r = make_res(8'd0, 1'b0, 1'b0, KIND_IGNORED);
          return;
        end
        dm_seg_cnt = b;
        dm_tbl_idx = 8'd0;
        if (b != 8'd0) dm_phase = PH_LACING;
      end
      PH_LACING: begin
        if (dm_tbl_idx < LACE_N) dm_lace[dm_tbl_idx] = b;
        if (8'(dm_tbl_idx + 8'd1) < dm_seg_cnt && dm_tbl_idx < LacingLastIdx) begin
          dm_tbl_idx++;
          return;
        end
        dm_phase   = PH_PAYLOAD;
        dm_tbl_idx = 8'd0;
        ends = skip_zero_entries(1'b0);
        if (ends) begin
          // packet carried over from an earlier page, closed by leading zero entries
          k = close_packet_now();
          if (dm_err != ERR_NONE) dm_phase = PH_HALTED;
          has_res = 1'b1;
          r = make_res(8'd0, 1'b0, 1'b1, k);
        end
      end
      PH_PAYLOAD: begin
        pos = dm_pkt_len;
        seg_len = entry_at(dm_tbl_idx);
        if (pos < MatchLen) begin
          if (b != HEAD_PAT[63 - 8 * pos -: 8]) dm_is_head = 1'b0;
          if (b != TAGS_PAT[63 - 8 * pos -: 8]) dm_is_tags = 1'b0;
        end else if (pos == ChanPos) begin
          dm_head_ch = b;
        end
        if (dm_pkt_len < LenSatMax) dm_pkt_len++;
        dm_pkt_open = 1'b1;
        ends = 1'b0;
        if (dm_seg_left > 8'd0) dm_seg_left--;
        if (dm_seg_left == 8'd0) begin
          ends = (seg_len < SegFull);
          dm_tbl_idx++;
          ends = skip_zero_entries(ends);
        end
        if (ends) begin
          k = close_packet_now();
          if (dm_err != ERR_NONE) dm_phase = PH_HALTED;
        end
        has_res = 1'b1;
        r = make_res(b, 1'b1, ends, k);
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // file generation

  // append one packet to the segment stream of the file being built
  task automatic add_packet(input pkt_e what, input int len, input logic [7:0] chans);
    int         n;
    logic [7:0] pb;
    for (int i = 0; i < len; i++) begin
      pb = 8'($urandom);
      if (what == PKT_HEAD && i < 8) pb = HEAD_PAT[63 - 8 * i -: 8];
      else if (what == PKT_HEAD && i == 9) pb = chans;
      else if (what == PKT_TAGS && i < 8) pb = TAGS_PAT[63 - 8 * i -: 8];
      body_q.push_back(pb);
    end
    n = len;
    while (n >= 255) begin
      lace_q.push_back(SegFull);
      n -= 255;
    end
    lace_q.push_back(8'(n));
  endtask

  task automatic queue_file();
    foreach (file_q[i]) ogg_bytes_q.push_back(ogg_item_t'{data: file_q[i], fs: (i == 0)});
    file_q.delete();
  endtask

  // cut the segment stream into pages; optionally corrupt one header byte,
  // insert a page without segments and drop the tail of the file
  task automatic emit_file(input int bad_page, input int bad_pos, input int max_segs,
                           input int empty_pg, input int cut_drop);
    int         pg;
    int         n;
    int         body_len;
    logic [7:0] hb;
    pg = 0;
    while (lace_q.size() > 0) begin
      n = (pg == empty_pg) ? 0 : $urandom_range(1, max_segs);
      if (n > lace_q.size()) n = lace_q.size();
      for (int i = 0; i < 27; i++) begin
        if (i < 4) hb = CAP_PAT[31 - 8 * i -: 8];
        else if (i == 4) hb = 8'd0;
        else if (i == 26) hb = 8'(n);
        else hb = 8'($urandom);
        if (pg == bad_page && i == bad_pos) hb ^= 8'($urandom_range(1, 255));
        file_q.push_back(hb);
      end
      body_len = 0;
      repeat (n) begin
        hb = lace_q.pop_front();
        body_len += hb;
        file_q.push_back(hb);
      end
      repeat (body_len) file_q.push_back(body_q.pop_front());
      pg++;
    end
    repeat (cut_drop) if (file_q.size() > 1) void'(file_q.pop_back());
    queue_file();
  endtask

  task automatic gen_random_file();
    int         sel;
    int         len;
    logic [7:0] chans;
    sel = $urandom_range(0, 99);
    // noise, sometimes behind a valid capture pattern
    if (sel < 10) begin
      if ($urandom_range(0, 1) == 1) begin
        for (int i = 0; i < 4; i++) file_q.push_back(CAP_PAT[31 - 8 * i -: 8]);
        file_q.push_back(8'd0);
      end
      repeat ($urandom_range(5, 40)) file_q.push_back(8'($urandom));
      queue_file();
      return;
    end
    if ($urandom_range(0, 9) == 0) add_packet(PKT_RAW, $urandom_range(0, 12), 8'd0);
    chans = 8'($urandom_range(1, 2));
    if ($urandom_range(0, 99) < 12) begin
      chans = 8'($urandom_range(3, 255));
      if ($urandom_range(0, 3) == 0) chans = 8'd0;
    end
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 9) : $urandom_range(10, 24);
    add_packet(PKT_HEAD, len, chans);
    if ($urandom_range(0, 9) != 0) add_packet(PKT_TAGS, $urandom_range(7, 20), 8'd0);
    repeat ($urandom_range(1, 4)) begin
      sel = $urandom_range(0, 99);
      len = (sel < 3) ? $urandom_range(250, 300) :
            (sel < 18) ? $urandom_range(13, 40) : $urandom_range(0, 12);
      add_packet(PKT_RAW, len, 8'd0);
    end
    emit_file(($urandom_range(0, 99) < 12) ? $urandom_range(0, 3) : -1,
              $urandom_range(0, 4),
              ($urandom_range(0, 19) == 0) ? 255 : $urandom_range(1, 6),
              ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : -1,
              ($urandom_range(0, 99) < 12) ? $urandom_range(1, 60) : 0);
  endtask

  // ---------------------------------------------------------------------------
  // input driver
  logic       drv_take;
  logic       drv_has;
  logic       drv_pause = 1'b0;
  logic       drv_calm;
  demux_res_t drv_res;
  ogg_item_t  drv_item;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      data_byte_i  <= 8'd0;
      file_start_i <= 1'b0;
    end else begin
      drv_take = in_valid_i && in_ready_o;
      if (drv_take) begin
        demux_byte(data_byte_i, file_start_i, drv_has, drv_res);
        if (drv_has) demux_out_q.push_back(drv_res);
        n_taken++;
        if (n_taken == PAUSE_AT) drv_pause = 1'b1;
      end
      if (drv_pause && demux_out_q.size() == 0) drv_pause = 1'b0;
      drv_calm = (n_taken >= 600 && n_taken < 800);
      if (in_valid_i && !drv_take) begin
        // transaction still pending, hold it
      end else if (ogg_bytes_q.size() > 0 && !drv_pause &&
                   (drv_calm || $urandom_range(0, 99) >= 31)) begin
        drv_item = ogg_bytes_q.pop_front();
        in_valid_i   <= 1'b1;
        data_byte_i  <= drv_item.data;
        file_start_i <= drv_item.fs;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output monitor
  demux_res_t mon_want;
  int         mon_hold = 0;
  logic       mon_hold_done = 1'b0;

  task automatic check_field(input string what, input logic [7:0] want_v,
                             input logic [7:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want_v, got_v);
      n_errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        n_results++;
        if (demux_out_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got byte %0h end %0b", $time,
                   payload_byte_o, packet_end_o);
          n_errors++;
        end else begin
          mon_want = demux_out_q.pop_front();
          check_field("payload_byte", mon_want.data, payload_byte_o);
          check_field("byte_valid", mon_want.dvalid, byte_valid_o);
          check_field("packet_end", mon_want.pend, packet_end_o);
          check_field("packet_kind", mon_want.kind, packet_kind_o);
          check_field("channel_count", mon_want.chans, channel_count_o);
          check_field("error_code", mon_want.err, error_code_o);
        end
      end
      // one long stall so the core backs up into its input
      if (n_results >= HOLD_AT && !mon_hold_done) begin
        mon_hold = HOLD_CYCLES;
        mon_hold_done = 1'b1;
      end
      if (mon_hold > 0) begin
        mon_hold--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= (n_results >= 400 && n_results < 600) || ($urandom_range(0, 99) >= 31);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // directed files, then random ones, then wait for the core to drain
  initial begin
    int q_was;
    int n_rand;
    clear_demux();

    // kinds in order: early packet, short head, head, tags, empty, one-byte packet,
    // a 255-byte packet closed by a zero entry on the next page, a second head;
    // one entry per page and one page without segments
    add_packet(PKT_RAW, 3, 8'd0);
    add_packet(PKT_HEAD, 9, 8'd2);
    add_packet(PKT_HEAD, 19, 8'd2);
    add_packet(PKT_TAGS, 8, 8'd0);
    add_packet(PKT_RAW, 0, 8'd0);
    add_packet(PKT_RAW, 1, 8'd0);
    add_packet(PKT_RAW, 255, 8'd0);
    add_packet(PKT_HEAD, 12, 8'd1);
    emit_file(-1, 0, 1, 1, 0);

    // pages of up to 255 lacing entries, mostly empty packets, file cut inside the last packet
    add_packet(PKT_HEAD, 10, 8'd1);
    add_packet(PKT_TAGS, 9, 8'd0);
    repeat (250) add_packet(PKT_RAW, 0, 8'd0);
    repeat (3) add_packet(PKT_RAW, 1, 8'd0);
    add_packet(PKT_RAW, 4, 8'd0);
    emit_file(-1, 0, 255, -1, 2);

    // bad channel count, bytes after it are ignored
    add_packet(PKT_HEAD, 10, 8'd3);
    add_packet(PKT_TAGS, 8, 8'd0);
    emit_file(-1, 0, 2, -1, 0);

    // broken capture pattern on the second page
    add_packet(PKT_HEAD, 10, 8'd1);
    add_packet(PKT_TAGS, 8, 8'd0);
    add_packet(PKT_RAW, 5, 8'd0);
    emit_file(1, 3, 1, -1, 0);

    // nonzero version on the first page
    add_packet(PKT_RAW, 4, 8'd0);
    emit_file(0, 4, 1, -1, 0);

    n_rand = 0;
    while (n_rand < RAND_BYTES) begin
      q_was = ogg_bytes_q.size();
      gen_random_file();
      n_rand += ogg_bytes_q.size() - q_was;
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (ogg_bytes_q.size() != 0 || in_valid_i || demux_out_q.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (n_errors == 0 && demux_out_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // run limit
  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d results outstanding", demux_out_q.size());
    $display("TB_ERROR");
    $finish;
  end

endmodule

>>> ogg_opus_page_demux_core.f
src/oggd_pkg.sv
src/oggd_ram.sv
src/oggd_pkt.sv
src/ogg_opus_page_demux_core.sv
tb/tb_ogg_opus_page_demux_core.sv
